/* rtl/per_bin_energy_rank_table_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the per-bin energy rank table
// Implication and next-cycle checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef PER_BIN_ENERGY_RANK_TABLE_ASSERT_SVH
`define PER_BIN_ENERGY_RANK_TABLE_ASSERT_SVH

// same-cycle implication
`define PBERT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBERT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pbert_pkg.sv */
// ----------------------------------------------------------------------------
// pbert_pkg
// Sizes, opcodes and controller/datapath interface types of the rank table.
// ----------------------------------------------------------------------------
`default_nettype none

package pbert_pkg;

  localparam int RANK_BINS   = 256;
  localparam int ETA_BINS    = 32;

  localparam int RANK_W      = $clog2(RANK_BINS);
  localparam int CNT_W       = $clog2(RANK_BINS + 1);
  localparam int COL_W       = $clog2(2 * ETA_BINS);
  localparam int ADDR_W      = RANK_W + COL_W;
  localparam int MEM_DEPTH   = RANK_BINS << COL_W;

  localparam int OPC_W       = 2;
  localparam int RANK_IN_W   = 9;
  localparam int ETA_W       = 8;
  localparam int ENERGY_W    = 16;
  localparam int RES_RANK_W  = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPC_W-1:0] OP_E2R   = 2'd1;
  localparam logic [OPC_W-1:0] OP_R2E   = 2'd2;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic load_out;
  } pbert_cmd_t;

  typedef struct packed {
    logic start_scan;
    logic scan_last;
    logic out_free;
  } pbert_stat_t;

endpackage

`default_nettype wire

/* rtl/per_bin_energy_rank_table.sv */
// ----------------------------------------------------------------------------
// per_bin_energy_rank_table
// Energy threshold table per rank, eta bin and eta sign, with rank lookup.
// ----------------------------------------------------------------------------
// One item is handled at a time; every item gives exactly one result. A write
// or a rank-to-energy query goes from acceptance straight to the done state,
// where its result is loaded once the output register is free; an
// energy-to-rank query first runs the column scan over all RANK_BINS ranks,
// which reads one threshold per cycle from the single read port of the table
// memory. Out-of-range eta indexes, out-of-range rank indexes of writes and
// rank-to-energy queries, and opcode 3 take the short path with error status.
// The result sits in an output register, so the next item is taken once the
// block is back at rest even while that result waits; the item after it then
// holds until the waiting result is taken. The table is not cleared by reset;
// entries must be written first.
// ----------------------------------------------------------------------------
`default_nettype none

module per_bin_energy_rank_table (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // rank_index[8:0], eta_index[16:9], eta_negative[17], energy_value[33:18]
  input  wire logic [pbert_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  wire logic [pbert_pkg::OPC_W-1:0]       in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // rank_result[7:0], energy_result[23:8]
  output logic [pbert_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status[0]
  output logic                                   out_tuser
);
  import pbert_pkg::*;

  pbert_cmd_t  cmd;
  pbert_stat_t stat;

  pbert_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbert_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire

/* rtl/pbert_ctrl.sv */
// ----------------------------------------------------------------------------
// pbert_ctrl
// Sequencer: takes one item, runs the column scan if needed, loads the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pbert_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire pbert_pkg::pbert_stat_t stat,
  output pbert_pkg::pbert_cmd_t   cmd
);
  import pbert_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.accept    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.start_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/pbert_dp.sv */
// ----------------------------------------------------------------------------
// pbert_dp
// Threshold memory, item registers, scan counter, compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbert_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [pbert_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [pbert_pkg::OPC_W-1:0]       in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [pbert_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tuser,
  input  wire pbert_pkg::pbert_cmd_t             cmd,
  output pbert_pkg::pbert_stat_t                 stat
);
  import pbert_pkg::*;

  logic [RANK_IN_W-1:0]  rank_in;
  logic [ETA_W-1:0]      eta_in;
  logic                  neg_in;
  logic [ENERGY_W-1:0]   energy_in;
  logic                  eta_ok;
  logic                  rank_ok;
  logic                  err_in;
  logic [COL_W-1:0]      col_in;
  logic                  wr_en;
  logic                  rd_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;

  logic [ENERGY_W-1:0]   thr_mem [MEM_DEPTH];
  logic [ENERGY_W-1:0]   rd_data_r;

  logic [OPC_W-1:0]      op_r, op_nxt;
  logic                  err_r, err_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ENERGY_W-1:0]   energy_r, energy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [RES_RANK_W-1:0] best_r, best_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic                  out_status_r, out_status_nxt;
  logic [RES_RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic [ENERGY_W-1:0]   out_energy_r, out_energy_nxt;

  assign rank_in   = in_tdata[8:0];
  assign eta_in    = in_tdata[16:9];
  assign neg_in    = in_tdata[17];
  assign energy_in = in_tdata[33:18];

  assign eta_ok  = (eta_in != '0) && (eta_in <= ETA_W'(ETA_BINS));
  assign rank_ok = rank_in < RANK_IN_W'(RANK_BINS);
  assign col_in  = COL_W'(eta_in - ETA_W'(1)) + (neg_in ? COL_W'(ETA_BINS) : COL_W'(0));

  always_comb begin
    case (in_tuser)
      OP_WRITE, OP_R2E: err_in = !(eta_ok && rank_ok);
      OP_E2R:           err_in = !eta_ok;
      default:          err_in = 1'b1;
    endcase
  end

  assign wr_en   = cmd.accept && (in_tuser == OP_WRITE) && !err_in;
  assign wr_addr = {rank_in[RANK_W-1:0], col_in};
  assign rd_en   = cmd.accept || cmd.scan_step;
  assign rd_addr = cmd.accept
                 ? {((in_tuser == OP_R2E) ? rank_in[RANK_W-1:0] : RANK_W'(0)), col_in}
                 : {cnt_r[RANK_W-1:0], col_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      thr_mem[wr_addr] <= energy_in;
    end
    if (rd_en) begin
      rd_data_r <= thr_mem[rd_addr];
    end
  end

  always_comb begin
    op_nxt     = op_r;
    err_nxt    = err_r;
    col_nxt    = col_r;
    energy_nxt = energy_r;
    cnt_nxt    = cnt_r;
    best_nxt   = best_r;
    if (cmd.accept) begin
      op_nxt     = in_tuser;
      err_nxt    = err_in;
      col_nxt    = col_in;
      energy_nxt = energy_in;
      cnt_nxt    = CNT_W'(1);
      best_nxt   = '0;
    end else if (cmd.scan_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (energy_r >= rd_data_r) begin
        best_nxt = RES_RANK_W'(cnt_r - CNT_W'(1));
      end
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_status_nxt = out_status_r;
    out_rank_nxt   = out_rank_r;
    out_energy_nxt = out_energy_r;
    if (cmd.load_out) begin
      out_tvalid_nxt = 1'b1;
      out_status_nxt = err_r;
      out_rank_nxt   = ((op_r == OP_E2R) && !err_r) ? best_r : '0;
      out_energy_nxt = ((op_r == OP_R2E) && !err_r) ? rd_data_r : '0;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    err_r        <= err_nxt;
    col_r        <= col_nxt;
    energy_r     <= energy_nxt;
    cnt_r        <= cnt_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_rank_r   <= out_rank_nxt;
    out_energy_r <= out_energy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign stat.start_scan = (in_tuser == OP_E2R) && eta_ok;
  assign stat.scan_last  = (cnt_r == CNT_W'(RANK_BINS));
  assign stat.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_energy_r, out_rank_r};

endmodule

`default_nettype wire

/* rtl/pbert_checker.sv */
// ----------------------------------------------------------------------------
// pbert_checker
// Port-level checks of the rank table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_bin_energy_rank_table_assert.svh"

module pbert_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [pbert_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                              out_tuser
);
  import pbert_pkg::*;

  `PBERT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  `PBERT_ASSERT_IMP(a_err_zero, clk, rst_n, out_tvalid && out_tuser,
    out_tdata == '0, "error result carries data")

  `PBERT_ASSERT_IMP(a_one_kind, clk, rst_n, out_tvalid,
    (out_tdata[7:0] == '0) || (out_tdata[23:8] == '0), "rank and energy both set")

  `PBERT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready,
    !in_tready, "second item taken while busy")

endmodule

bind per_bin_energy_rank_table pbert_checker u_pbert_checker (.*);

`default_nettype wire

/* test/per_bin_energy_rank_table_tb.sv */
// ----------------------------------------------------------------------------
// per_bin_energy_rank_table_tb
// Self-checking stream testbench for the per-bin energy rank table. A queue of
// items (directed corner cases, full column fills, then mixed queries, writes
// and malformed items) feeds a clocked driver. A shadow copy of the threshold
// table predicts every result. A clocked monitor compares each result, field by
// field, with the oldest prediction. Both sides stall at random in two patterns, a
// third has no random stalls, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module per_bin_energy_rank_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbert_pkg::*;

  localparam int COLUMNS     = 2 * ETA_BINS;
  localparam int TABLE_DEPTH = RANK_BINS * COLUMNS;
  localparam int HOLD_LEN    = 600;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OPC_W-1:0]     opcode;
    logic [RANK_IN_W-1:0] rank_index;
    logic [ETA_W-1:0]     eta_index;
    logic                 eta_negative;
    logic [ENERGY_W-1:0]  energy_value;
    int                   phase;
  } rank_item_t;

  typedef struct packed {
    logic                  status;
    logic [RES_RANK_W-1:0] rank_result;
    logic [ENERGY_W-1:0]   energy_result;
  } rank_answer_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OPC_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  rank_item_t   pending_items[$];
  rank_answer_t expected_answers[$];
  rank_item_t   cur_item;
  logic [ENERGY_W-1:0] threshold_shadow [TABLE_DEPTH];

  bit                  gen_written [TABLE_DEPTH];
  logic [ENERGY_W-1:0] gen_value [TABLE_DEPTH];
  bit                  col_full [COLUMNS];
  int                  full_cols[$];
  int                  written_addrs[$];
  int                  gen_phase;

  int tx_idle_pct [4] = '{31, 31, 55, 0};
  int rx_idle_pct [4] = '{55, 55, 31, 0};
  int drive_phase = 0;
  int accepted_count = 0;
  int hold_start = -1;
  int hold_cnt = 0;
  logic rx_hold = 1'b0;
  bit hold_done = 1'b0;

  int fail_count = 0;
  int n_writes = 0;
  int n_e2r = 0;
  int n_r2e = 0;
  int n_error_results = 0;

  per_bin_energy_rank_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // rank_index[8:0], eta_index[16:9], eta_negative[17], energy_value[33:18]
    .in_tdata   (in_tdata),
    // opcode[1:0]
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // rank_result[7:0], energy_result[23:8]
    .out_tdata  (out_tdata),
    // status[0]
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rank_answer_t rank_table_answer(input rank_item_t it);
    rank_answer_t ans;
    int col;
    int r;
    bit eta_ok;
    bit rank_ok;
    ans = '0;
    ans.status = 1'b1;
    eta_ok = it.eta_index >= 1 && it.eta_index <= ETA_BINS;
    rank_ok = it.rank_index < RANK_BINS;
    col = int'(it.eta_index) - 1 + (it.eta_negative ? ETA_BINS : 0);
    case (it.opcode)
      OP_WRITE: if (eta_ok && rank_ok) begin
        threshold_shadow[it.rank_index * COLUMNS + col] = it.energy_value;
        ans.status = 1'b0;
      end
      OP_E2R: if (eta_ok) begin
        for (r = 0; r < RANK_BINS; r++) begin
          if (it.energy_value >= threshold_shadow[r * COLUMNS + col])
            ans.rank_result = r[RES_RANK_W-1:0];
        end
        ans.status = 1'b0;
      end
      OP_R2E: if (eta_ok && rank_ok) begin
        ans.energy_result = threshold_shadow[it.rank_index * COLUMNS + col];
        ans.status = 1'b0;
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic queue_request(input logic [OPC_W-1:0] op, input int rank, input int eta,
                               input bit neg, input int energy);
    rank_item_t it;
    int addr;
    it.opcode       = op;
    it.rank_index   = rank[RANK_IN_W-1:0];
    it.eta_index    = eta[ETA_W-1:0];
    it.eta_negative = neg;
    it.energy_value = energy[ENERGY_W-1:0];
    it.phase        = gen_phase;
    if (op == OP_WRITE && eta >= 1 && eta <= ETA_BINS && rank < RANK_BINS) begin
      addr = rank * COLUMNS + eta - 1 + (neg ? ETA_BINS : 0);
      if (!gen_written[addr])
        written_addrs.push_back(addr);
      gen_written[addr] = 1'b1;
      gen_value[addr] = energy[ENERGY_W-1:0];
    end
    pending_items.push_back(it);
  endtask

  task automatic queue_noise();
    int op;
    int rank;
    int eta;
    int col;
    int bad_eta;
    bit neg;
    op = $urandom_range(3);
    rank = $urandom_range(511);
    eta = $urandom_range(1) ? $urandom_range(255) : $urandom_range(ETA_BINS, 1);
    neg = $urandom_range(1);
    bad_eta = $urandom_range(1) ? 0 : $urandom_range(255, ETA_BINS + 1);
    if (eta >= 1 && eta <= ETA_BINS) begin
      col = eta - 1 + (neg ? ETA_BINS : 0);
      // steer away from reads of never-written thresholds
      if (op == OP_E2R && !col_full[col])
        eta = bad_eta;
      else if (op == OP_R2E && rank < RANK_BINS && !gen_written[rank * COLUMNS + col])
        eta = bad_eta;
    end
    queue_request(op[OPC_W-1:0], rank, eta, neg, $urandom_range(65535));
  endtask

  task automatic fill_column(input int col);
    int pattern;
    int level;
    int val;
    int r;
    pattern = $urandom_range(2);
    level = 0;
    for (r = 0; r < RANK_BINS; r++) begin
      case (pattern)
        0: begin
          level = level + $urandom_range(255);
          if (level > 65535)
            level = 65535;
          val = level;
        end
        1: val = $urandom_range(65535);
        default: val = $urandom_range(3) * 16'h5555;
      endcase
      queue_request(OP_WRITE, r, col % ETA_BINS + 1, col / ETA_BINS, val);
      if ($urandom_range(99) < 8)
        queue_noise();
    end
    col_full[col] = 1'b1;
    full_cols.push_back(col);
  endtask

  task automatic queue_mixed(input int count);
    int n;
    int sel;
    int col;
    int addr;
    int energy;
    int rank;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        col = full_cols[$urandom_range(full_cols.size() - 1)];
        case ($urandom_range(3))
          0: energy = $urandom_range(65535);
          1: energy = gen_value[$urandom_range(RANK_BINS - 1) * COLUMNS + col];
          2: energy = (gen_value[$urandom_range(RANK_BINS - 1) * COLUMNS + col]
                       + ($urandom_range(1) ? 1 : -1)) & 16'hFFFF;
          default: energy = $urandom_range(1) ? 65535 : 0;
        endcase
        queue_request(OP_E2R, $urandom_range(511), col % ETA_BINS + 1, col / ETA_BINS, energy);
      end else if (sel < 60) begin
        addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
        col = addr % COLUMNS;
        queue_request(OP_R2E, addr / COLUMNS, col % ETA_BINS + 1, col / ETA_BINS,
                      $urandom_range(65535));
      end else if (sel < 80) begin
        col = $urandom_range(1) ? full_cols[$urandom_range(full_cols.size() - 1)]
                                : $urandom_range(COLUMNS - 1);
        rank = $urandom_range(RANK_BINS - 1);
        queue_request(OP_WRITE, rank, col % ETA_BINS + 1, col / ETA_BINS,
                      $urandom_range(65535));
      end else begin
        queue_noise();
      end
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(rank_table_answer(cur_item));
        accepted_count <= accepted_count + 1;
        case (cur_item.opcode)
          OP_WRITE: n_writes++;
          OP_E2R:   n_e2r++;
          OP_R2E:   n_r2e++;
          default: ;
        endcase
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 &&
            $urandom_range(99) >= tx_idle_pct[pending_items[0].phase]) begin
          cur_item = pending_items.pop_front();
          drive_phase <= cur_item.phase;
          in_tvalid <= 1'b1;
          in_tdata <= IN_TDATA_W'({cur_item.energy_value, cur_item.eta_negative,
                                   cur_item.eta_index, cur_item.rank_index});
          in_tuser <= cur_item.opcode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    rank_answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (out_tuser)
          n_error_results++;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d rank %0d energy %0d",
                   $time, out_tuser, out_tdata[7:0], out_tdata[23:8]);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("rank_result", want.rank_result, out_tdata[7:0]);
          check_field("energy_result", want.energy_result, out_tdata[23:8]);
        end
      end
      out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct[drive_phase]);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold <= 1'b0;
      hold_cnt <= 0;
    end else if (rx_hold) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN - 1) begin
        rx_hold <= 1'b0;
        hold_done <= 1'b1;
      end
    end else if (!hold_done && accepted_count == hold_start) begin
      rx_hold <= 1'b1;
      hold_cnt <= 0;
    end
  end

  initial begin
    int p;
    int col;
    gen_phase = 0;
    queue_request(OP_WRITE, 0, 1, 1'b0, 0);
    queue_request(OP_WRITE, RANK_BINS - 1, ETA_BINS, 1'b1, 65535);
    queue_request(OP_R2E, 0, 1, 1'b0, 65535);
    queue_request(OP_R2E, RANK_BINS - 1, ETA_BINS, 1'b1, 0);
    queue_request(OP_WRITE, 0, 0, 1'b0, 16'h1234);
    queue_request(OP_WRITE, RANK_BINS - 1, ETA_BINS + 1, 1'b1, 16'h4321);
    queue_request(OP_WRITE, 511, 255, 1'b1, 16'hAAAA);
    queue_request(OP_WRITE, RANK_BINS, 1, 1'b0, 16'h5555);
    queue_request(OP_WRITE, 511, ETA_BINS, 1'b1, 16'h7777);
    queue_request(OP_R2E, RANK_BINS, 1, 1'b0, 0);
    queue_request(OP_R2E, 0, 0, 1'b0, 0);
    queue_request(OP_R2E, 0, ETA_BINS + 1, 1'b0, 0);
    queue_request(OP_E2R, 0, 0, 1'b0, 65535);
    queue_request(OP_E2R, 511, 255, 1'b1, 65535);
    queue_request(OP_UNUSED, 0, 1, 1'b0, 0);
    queue_request(OP_UNUSED, 511, 255, 1'b1, 65535);
    queue_request(OP_R2E, 0, 1, 1'b0, 0);
    queue_request(OP_R2E, RANK_BINS - 1, ETA_BINS, 1'b1, 0);

    for (p = 1; p <= 3; p++) begin
      gen_phase = p;
      if (p == 3)
        hold_start = pending_items.size() + 30;
      if (p == 1) begin
        col = 0;
      end else if (p == 2) begin
        col = COLUMNS - 1;
      end else begin
        do col = $urandom_range(COLUMNS - 1); while (col_full[col]);
      end
      fill_column(col);
      if (p == 1) begin
        queue_request(OP_E2R, 0, 1, 1'b0, 0);
        queue_request(OP_E2R, 511, 1, 1'b0, 65535);
        queue_request(OP_E2R, RANK_BINS - 1, 1, 1'b0, 16'h8000);
      end
      queue_mixed(120);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid)
      @(posedge clk);
    while (expected_answers.size() != 0)
      @(posedge clk);
    repeat (RANK_BINS + 20) @(posedge clk);

    if (expected_answers.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_answers.size());
      fail_count++;
    end
    $display("covered %0d writes, %0d energy-to-rank and %0d rank-to-energy queries,",
             n_writes, n_e2r, n_r2e);
    $display("%0d error results, over %0d filled columns and three stall patterns",
             n_error_results, full_cols.size());
    if (fail_count == 0) begin
      $display("per_bin_energy_rank_table_tb: PASS");
    end else begin
      $display("per_bin_energy_rank_table_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout at %0t", $time);
    $display("per_bin_energy_rank_table_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/pbert_pkg.sv
rtl/pbert_ctrl.sv
rtl/pbert_dp.sv
rtl/per_bin_energy_rank_table.sv
rtl/pbert_checker.sv
test/per_bin_energy_rank_table_tb.sv
